[sv/u2a_pkg.sv]
`timescale 1ns / 1ps

package u2a_pkg;

    // Number of input bits that take part in the conversion.
    localparam int VALUE_WIDTH = 64;
    // Digit positions held in the digit register.
    localparam int MAX_DIGITS  = 20;

    localparam int DIG_W     = 4 * MAX_DIGITS;
    localparam int BIT_CNT_W = $clog2(VALUE_WIDTH);
    localparam int DIG_CNT_W = $clog2(MAX_DIGITS + 1);

    localparam logic [6:0] CHAR_ZERO = 7'd48;
    localparam logic [6:0] CHAR_A    = 7'd65;
    localparam logic [3:0] DEC_BASE  = 4'd10;
    // A BCD digit at or above this value is corrected before it doubles.
    localparam logic [3:0] DABBLE_MIN = 4'd5;
    localparam logic [3:0] DABBLE_ADD = 4'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic conv;
        logic skip;
        logic emit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic bits_done;
        logic top_zero;
        logic cnt_one;
        logic overflow;
    } t_dp_sts;

    function automatic logic [6:0] digit_to_ascii(input logic [3:0] d);
        logic [6:0] c;
        if (d >= DEC_BASE) begin
            c = CHAR_A + {3'd0, d - DEC_BASE};
        end else begin
            c = CHAR_ZERO + {3'd0, d};
        end
        return c;
    endfunction

endpackage

[sv/unsigned_to_ascii_digits_core.sv]
`timescale 1ns / 1ps

// Channel | Direction | Handshake                | Payload
// --------+-----------+--------------------------+---------------------------
// input   | in        | i_in_valid / o_in_stall   | i_value[63:0], i_hex_mode
// output  | out       | o_out_valid / i_out_stall | o_digit_char[6:0], o_last
//
// An accepted value goes through bit-serial double dabble over all VALUE_WIDTH bits
// (64; plain shifting in hex mode), then a leading-zero skip, then one digit per transfer.
// A new value is taken only after the last digit of the run has been transferred,
// so output stalls also hold back the next input transfer.
// Reset (synchronous, active low) returns the controller to idle; no clearing pass.
// Output stalls hold the current digit; the input stays stalled until the run ends.

module unsigned_to_ascii_digits_core
    import u2a_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [63:0] i_value,
    input  logic        i_hex_mode,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [6:0]  o_digit_char,
    output logic        o_last
);

    // Commands and status between the sequencing controller and the datapath.
    t_dp_cmd cmd;
    t_dp_sts sts;

    // The controller walks through idle, conversion, leading-zero skip and
    // emit; it only issues commands and never touches the digits itself.
    u2a_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // The datapath holds the value shifter, the digit register, and the bit
    // and digit counters. The top digit of the digit register drives the
    // output directly, so a stalled transfer keeps its payload.
    u2a_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_value      (i_value),
        .i_hex_mode   (i_hex_mode),
        .o_sts        (sts),
        .o_digit_char (o_digit_char),
        .o_last       (o_last)
    );

endmodule

[sv/u2a_dpath.sv]
`timescale 1ns / 1ps

module u2a_dpath
    import u2a_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_dp_cmd       i_cmd,
    input  logic [63:0]   i_value,
    input  logic          i_hex_mode,
    output t_dp_sts       o_sts,
    output logic [6:0]    o_digit_char,
    output logic          o_last
);

    logic [VALUE_WIDTH-1:0] r_value, n_value;
    logic                   r_hex, n_hex;
    logic [DIG_W-1:0]       r_digits, n_digits;
    logic [BIT_CNT_W-1:0]   r_bit_cnt, n_bit_cnt;
    logic [DIG_CNT_W-1:0]   r_dig_cnt, n_dig_cnt;
    logic                   r_ovf, n_ovf;
    logic [DIG_W-1:0]       corrected;

    // Add-3 correction on every BCD digit at or above DABBLE_MIN; hex mode shifts the bits unchanged.
    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (!r_hex && (r_digits[4*i +: 4] >= DABBLE_MIN)) begin
                corrected[4*i +: 4] = r_digits[4*i +: 4] + DABBLE_ADD;
            end else begin
                corrected[4*i +: 4] = r_digits[4*i +: 4];
            end
        end
    end

    always_comb begin
        n_value   = r_value;
        n_hex     = r_hex;
        n_digits  = r_digits;
        n_bit_cnt = r_bit_cnt;
        n_dig_cnt = r_dig_cnt;
        n_ovf     = r_ovf;
        if (i_cmd.load) begin
            n_value   = i_value[VALUE_WIDTH-1:0];
            n_hex     = i_hex_mode;
            n_digits  = '0;
            n_bit_cnt = BIT_CNT_W'(VALUE_WIDTH - 1);
            n_dig_cnt = DIG_CNT_W'(MAX_DIGITS);
            n_ovf     = 1'b0;
        end else if (i_cmd.conv) begin
            n_digits  = {corrected[DIG_W-2:0], r_value[VALUE_WIDTH-1]};
            n_ovf     = r_ovf | corrected[DIG_W-1];
            n_value   = {r_value[VALUE_WIDTH-2:0], 1'b0};
            n_bit_cnt = r_bit_cnt - 1'b1;
        end else if (i_cmd.skip || i_cmd.emit) begin
            n_digits  = {r_digits[DIG_W-5:0], 4'd0};
            n_dig_cnt = r_dig_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_cnt <= '0;
            r_dig_cnt <= '0;
            r_ovf     <= 1'b0;
        end else begin
            r_bit_cnt <= n_bit_cnt;
            r_dig_cnt <= n_dig_cnt;
            r_ovf     <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value  <= n_value;
        r_hex    <= n_hex;
        r_digits <= n_digits;
    end

    assign o_sts.bits_done = (r_bit_cnt == '0);
    assign o_sts.top_zero  = (r_digits[DIG_W-1 -: 4] == 4'd0);
    assign o_sts.cnt_one   = (r_dig_cnt == DIG_CNT_W'(1));
    assign o_sts.overflow  = r_ovf;

    assign o_digit_char = digit_to_ascii(r_digits[DIG_W-1 -: 4]);
    assign o_last       = o_sts.cnt_one;

endmodule

[sv/u2a_ctrl.sv]
`timescale 1ns / 1ps

module u2a_ctrl
    import u2a_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_out_stall,
    input  t_dp_sts  i_sts,
    output t_dp_cmd  o_cmd,
    output logic     o_in_stall,
    output logic     o_out_valid
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CONV;
                end
            end
            ST_CONV: begin
                o_cmd.conv = 1'b1;
                if (i_sts.bits_done) begin
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                // Leading zeros are dropped, never the last digit, unless the value overflowed the digits.
                if (!i_sts.overflow && i_sts.top_zero && !i_sts.cnt_one) begin
                    o_cmd.skip = 1'b1;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.cnt_one) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_load_starts_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == ST_CONV))
        else $error("accepted input did not start a conversion");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && i_sts.cnt_one) |=> (r_state == ST_IDLE))
        else $error("run did not end after its last digit");

    a_no_skip_on_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.skip |-> (!i_sts.overflow && i_sts.top_zero))
        else $error("digit dropped that should have been emitted");

    a_emit_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(i_sts.cnt_one)))
        else $error("stalled digit changed");

endmodule
